/* src/wpp_pkg.sv */
// Shared types and constants for the WAVE PCM stream parser.
package wpp_pkg;

  // Parser phases while walking the file.
  typedef enum logic [2:0] {
    PH_FORM = 3'd0,
    PH_HEAD = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5
  } phase_e;

  // Result kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_FORMAT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NO_FMT     = 3'd0;
  localparam logic [2:0] ERR_NOT_PCM    = 3'd1;
  localparam logic [2:0] ERR_BAD_BITS   = 3'd2;
  localparam logic [2:0] ERR_NO_DATA    = 3'd3;
  localparam logic [2:0] ERR_ZERO_ALIGN = 3'd4;

  // Chunk tags as they land little-endian in a 32-bit word.
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [3:0]  FORM_HDR_BYTES = 4'd12;
  localparam logic [15:0] PCM_TAG        = 16'd1;
  localparam logic [15:0] SAMPLE_MIN     = 16'h8000;
  localparam logic [15:0] SAMPLE_CLAMP   = 16'h8001;

  // One result item.
  typedef struct packed {
    logic [1:0]        kind;
    logic signed [15:0] sample_value;
    logic              final_sample;
    logic [31:0]       rate_hz;
    logic [15:0]       block_bytes;
    logic [2:0]        error_code;
  } result_t;

endpackage

/* src/wpp_core.sv */
// Parser state registers and the per-byte next-state and result logic.
module wpp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             eof_i,
  output logic             res_valid_o,
  output wpp_pkg::result_t res_o
);
  import wpp_pkg::*;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  byte_count;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_left;
    logic [15:0] format_tag;
    logic [31:0] rate_store;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic        format_seen;
    logic [15:0] block_pos;
    logic [7:0]  low_byte_hold;
    logic        error_sticky;
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] code;
  } fmt_chk_t;

  state_t  st_q, st_d;
  result_t res_d;
  logic    res_valid_d;

  // Data phase helpers.
  logic [16:0] need;
  logic        blk_complete;
  logic [31:0] left_after_blk;
  logic        blk_final;
  logic [16:0] pos_inc;
  logic [15:0] raw16;
  logic        emit;

  function automatic fmt_chk_t check_fmt(input logic [15:0] tag, input logic [15:0] bits,
                                         input logic [15:0] align);
    fmt_chk_t r;
    r.ok   = 1'b0;
    r.code = ERR_NOT_PCM;
    if (tag != PCM_TAG) begin
      r.code = ERR_NOT_PCM;
    end else if (bits != 16'd8 && bits != 16'd16) begin
      r.code = ERR_BAD_BITS;
    end else if (align == '0) begin
      r.code = ERR_ZERO_ALIGN;
    end else begin
      r.ok = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    need           = {1'b0, st_q.block_align} - {1'b0, st_q.block_pos};
    blk_complete   = st_q.chunk_left >= {15'd0, need};
    left_after_blk = st_q.chunk_left - {15'd0, need};
    blk_final      = blk_complete && (left_after_blk < {16'd0, st_q.block_align});
    pos_inc        = {1'b0, st_q.block_pos} + 17'd1;
    emit           = 1'b0;
    raw16          = '0;
    if (st_q.bits_per_sample == 16'd8) begin
      if (st_q.block_pos == '0) begin
        emit  = 1'b1;
        raw16 = {byte_i ^ 8'h80, 8'h00};
      end
    end else begin
      if (st_q.block_pos == '0) begin
        if (st_q.block_align == 16'd1) begin
          emit  = 1'b1;
          raw16 = {8'h00, byte_i};
        end
      end else if (st_q.block_pos == 16'd1) begin
        emit  = 1'b1;
        raw16 = {byte_i, st_q.low_byte_hold};
      end
      if (raw16 == SAMPLE_MIN) begin
        raw16 = SAMPLE_CLAMP;
      end
    end
  end

  always_comb begin
    fmt_chk_t chk;
    st_d        = st_q;
    res_d       = '0;
    res_valid_d = 1'b0;
    chk         = '0;

    if (!st_q.error_sticky) begin
      case (st_q.phase)
        PH_FORM: begin
          st_d.byte_count = st_q.byte_count + 4'd1;
          if (st_d.byte_count >= FORM_HDR_BYTES) begin
            st_d.phase      = PH_HEAD;
            st_d.byte_count = '0;
          end
        end
        PH_HEAD: begin
          if (st_q.byte_count < 4'd4) begin
            st_d.chunk_tag = {byte_i, st_q.chunk_tag[31:8]};
          end else begin
            st_d.chunk_left = {byte_i, st_q.chunk_left[31:8]};
          end
          if (st_q.byte_count < 4'd7) begin
            st_d.byte_count = st_q.byte_count + 4'd1;
          end else begin
            st_d.byte_count = '0;
            if (st_d.chunk_tag == TAG_DATA) begin
              if (!st_q.format_seen) begin
                st_d.error_sticky = 1'b1;
                res_valid_d       = 1'b1;
                res_d.kind        = KIND_ERROR;
                res_d.error_code  = ERR_NO_FMT;
              end else begin
                st_d.block_pos = '0;
                st_d.phase     = (st_d.chunk_left == '0) ? PH_DONE : PH_DATA;
              end
            end else if (st_d.chunk_tag == TAG_FMT && !st_q.format_seen) begin
              st_d.format_tag      = '0;
              st_d.rate_store      = '0;
              st_d.block_align     = '0;
              st_d.bits_per_sample = '0;
              if (st_d.chunk_left == '0) begin
                // Empty fmt body: every field reads as zero, so the tag check fails.
                st_d.error_sticky = 1'b1;
                res_valid_d       = 1'b1;
                res_d.kind        = KIND_ERROR;
                res_d.error_code  = ERR_NOT_PCM;
              end else begin
                st_d.phase = PH_FMT;
              end
            end else if (st_d.chunk_left != '0) begin
              st_d.phase = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          case (st_q.byte_count)
            4'd0:  st_d.format_tag[7:0]       = st_q.format_tag[7:0] | byte_i;
            4'd1:  st_d.format_tag[15:8]      = st_q.format_tag[15:8] | byte_i;
            4'd4:  st_d.rate_store[7:0]       = st_q.rate_store[7:0] | byte_i;
            4'd5:  st_d.rate_store[15:8]      = st_q.rate_store[15:8] | byte_i;
            4'd6:  st_d.rate_store[23:16]     = st_q.rate_store[23:16] | byte_i;
            4'd7:  st_d.rate_store[31:24]     = st_q.rate_store[31:24] | byte_i;
            4'd12: st_d.block_align[7:0]      = st_q.block_align[7:0] | byte_i;
            4'd13: st_d.block_align[15:8]     = st_q.block_align[15:8] | byte_i;
            4'd14: st_d.bits_per_sample[7:0]  = st_q.bits_per_sample[7:0] | byte_i;
            4'd15: st_d.bits_per_sample[15:8] = st_q.bits_per_sample[15:8] | byte_i;
            default: ;
          endcase
          st_d.chunk_left = st_q.chunk_left - 32'd1;
          st_d.byte_count = st_q.byte_count + 4'd1;
          if (st_q.byte_count == 4'd15 || st_d.chunk_left == '0) begin
            st_d.byte_count = '0;
            st_d.phase      = (st_d.chunk_left == '0) ? PH_HEAD : PH_SKIP;
            chk = check_fmt(st_d.format_tag, st_d.bits_per_sample, st_d.block_align);
            res_valid_d = 1'b1;
            if (chk.ok) begin
              st_d.format_seen  = 1'b1;
              res_d.kind        = KIND_FORMAT;
              res_d.rate_hz     = st_d.rate_store;
              res_d.block_bytes = st_d.block_align;
            end else begin
              st_d.error_sticky = 1'b1;
              res_d.kind        = KIND_ERROR;
              res_d.error_code  = chk.code;
            end
          end
        end
        PH_SKIP: begin
          st_d.chunk_left = st_q.chunk_left - 32'd1;
          if (st_d.chunk_left == '0) begin
            st_d.phase      = PH_HEAD;
            st_d.byte_count = '0;
          end
        end
        PH_DATA: begin
          if (st_q.bits_per_sample != 16'd8 && st_q.block_pos == '0) begin
            st_d.low_byte_hold = byte_i;
          end
          if (emit && blk_complete) begin
            res_valid_d        = 1'b1;
            res_d.kind         = KIND_SAMPLE;
            res_d.sample_value = raw16;
            res_d.final_sample = blk_final;
          end
          st_d.chunk_left = st_q.chunk_left - 32'd1;
          st_d.block_pos  = (pos_inc >= {1'b0, st_q.block_align}) ? '0 : pos_inc[15:0];
          if (st_d.chunk_left == '0) begin
            st_d.phase = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    if (eof_i) begin
      // A file that never reached its data chunk ends in an error that
      // overrides any format result from the same byte.
      if (!st_d.error_sticky && st_d.phase < PH_DATA) begin
        res_d            = '0;
        res_valid_d      = 1'b1;
        res_d.kind       = KIND_ERROR;
        res_d.error_code = st_d.format_seen ? ERR_NO_DATA : ERR_NO_FMT;
      end
      st_d       = '0;
      st_d.phase = PH_FORM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      st_q.phase <= PH_FORM;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign res_valid_o = step_i && res_valid_d;
  assign res_o       = res_d;

  a_sticky_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.error_sticky && !eof_i |-> !res_valid_o)
    else $error("result produced while an error is pending");

  a_data_needs_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_DATA |-> st_q.format_seen && st_q.block_align != '0)
    else $error("data phase without an accepted format");

  a_pos_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PH_DATA |-> st_q.block_pos < st_q.block_align)
    else $error("block position outside the block");

  a_eof_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eof_i |=> st_q.phase == PH_FORM && !st_q.error_sticky)
    else $error("parser did not restart after the last byte");

endmodule

/* src/wpp_out_reg.sv */
// Result register that holds one item until the receiver takes it.
module wpp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  wpp_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             valid_o,
  output wpp_pkg::result_t res_o
);
  import wpp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || ready_i)
    else $error("held result overwritten before delivery");

endmodule

/* src/wav_pcm_stream_parser_top.sv */
// Top level of the WAVE PCM stream parser.
//
// The input channel takes one item per byte of a RIFF WAVE file: file_byte_i
// and end_of_file_i, which marks the last byte. The output channel gives at
// most one result item per input byte: a sample, an accepted format or an
// error, told apart by kind_o. Fields that do not belong to the kind are zero.
// Both channels use valid and ready; an item moves when both are high.
//
// An accepted byte is registered, worked on against the parser state once
// the result slot is free, and any result lands in the output register that
// drives out_valid_o. The parser takes one byte per cycle while the output
// is not stalled; the state update is the only loop. When the receiver
// stalls, the held result keeps the working stage waiting and the input
// register fills, after which in_ready_o drops.
// Reset clears the parser to the start of a file and empties both registers.
// The byte marked end_of_file also returns the parser to the start of a file.
module wav_pcm_stream_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         file_byte_i,
  input  logic               end_of_file_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [15:0] sample_value_o,
  output logic               final_sample_o,
  output logic [31:0]        rate_hz_o,
  output logic [15:0]        block_bytes_o,
  output logic [2:0]         error_code_o
);
  import wpp_pkg::*;

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       eof_q;

  // The working stage fires when a byte is waiting and the result slot
  // is empty or being emptied this cycle.
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign step       = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= file_byte_i;
      eof_q  <= end_of_file_i;
    end
  end

  wpp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .eof_i       (eof_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wpp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .res_o   (out_res)
  );

  assign kind_o         = out_res.kind;
  assign sample_value_o = out_res.sample_value;
  assign final_sample_o = out_res.final_sample;
  assign rate_hz_o      = out_res.rate_hz;
  assign block_bytes_o  = out_res.block_bytes;
  assign error_code_o   = out_res.error_code;

endmodule

/* verif/wav_pcm_stream_parser_top_tb.sv */
// Self-checking testbench for the WAVE PCM stream parser top level.
module wav_pcm_stream_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpp_pkg::*;

  // A hold-off this long keeps results from draining, so the input stalls.
  localparam int unsigned HOLDOFF_CYCLES = 300;
  // The watchdog allows for the hold-off plus the longest sender gap.
  localparam int unsigned IDLE_LIMIT     = 2000;
  // Extra wait at the end once no result is still awaited.
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned RANDOM_BYTES   = 1800;
  localparam int unsigned MAX_REPORTS    = 100;

  // How the receiver paces out_ready_i between hold-offs.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         file_byte_i;
  logic               end_of_file_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic signed [15:0] sample_value_o;
  logic               final_sample_o;
  logic [31:0]        rate_hz_o;
  logic [15:0]        block_bytes_o;
  logic [2:0]         error_code_o;

  wav_pcm_stream_parser_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .file_byte_i    (file_byte_i),
    .end_of_file_i  (end_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .sample_value_o (sample_value_o),
    .final_sample_o (final_sample_o),
    .rate_hz_o      (rate_hz_o),
    .block_bytes_o  (block_bytes_o),
    .error_code_o   (error_code_o)
  );

  // Predicted parser state, advanced once per accepted byte.
  phase_e      walk_phase;
  logic [3:0]  hdr_index;
  logic [31:0] tag_word;
  logic [31:0] body_left;
  logic [15:0] fmt_code;
  logic [31:0] rate_word;
  logic [15:0] align_bytes;
  logic [15:0] sample_bits;
  logic        fmt_ok;
  logic [15:0] block_index;
  logic [7:0]  low_byte;
  logic        stuck_error;

  // Results predicted but not yet seen on the output, oldest first.
  result_t     awaited_results[$];
  // The file being assembled before it is sent byte by byte.
  logic [7:0]  file_q[$];

  int unsigned bytes_sent;
  int unsigned error_count;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned holdoff_requests;
  int unsigned holdoff_served;
  int unsigned holdoff_left;
  int unsigned mode_left;
  int unsigned rx_tick;
  rx_mode_e    rx_mode;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t ns: %s", $realtime, what);
    end
  endtask

  // Parser back to the start of a file: after reset and after the last byte.
  function automatic void clear_parser();
    walk_phase  = PH_FORM;
    hdr_index   = '0;
    tag_word    = '0;
    body_left   = '0;
    fmt_code    = '0;
    rate_word   = '0;
    align_bytes = '0;
    sample_bits = '0;
    fmt_ok      = 1'b0;
    block_index = '0;
    low_byte    = '0;
    stuck_error = 1'b0;
  endfunction

  function automatic result_t error_result(input logic [2:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    stuck_error = 1'b1;
    return r;
  endfunction

  // Checks the stored format fields in their fixed order of priority.
  function automatic result_t judge_format();
    result_t r;
    r = '0;
    if (fmt_code != PCM_TAG) begin
      r = error_result(ERR_NOT_PCM);
    end else if (sample_bits != 16'd8 && sample_bits != 16'd16) begin
      r = error_result(ERR_BAD_BITS);
    end else if (align_bytes == 16'd0) begin
      r = error_result(ERR_ZERO_ALIGN);
    end else begin
      fmt_ok = 1'b1;
      r.kind = KIND_FORMAT;
      r.rate_hz = rate_word;
      r.block_bytes = align_bytes;
    end
    return r;
  endfunction

  // Advances the predicted parser by one byte and queues any result it gives.
  task automatic parse_wave_byte(input logic [7:0] b, input logic eof);
    result_t     res;
    logic        produced;
    int unsigned field_off;
    longint      left_before;
    longint      need;
    logic        complete;
    logic        no_more;
    logic        emit;
    logic [15:0] raw;
    logic [15:0] sample;
    res = '0;
    produced = 1'b0;
    emit = 1'b0;
    raw = '0;
    sample = '0;
    if (!stuck_error) begin
      case (walk_phase)
        PH_FORM: begin
          hdr_index = hdr_index + 4'd1;
          if (hdr_index >= FORM_HDR_BYTES) begin
            walk_phase = PH_HEAD;
            hdr_index = '0;
          end
        end
        PH_HEAD: begin
          // Tag then size, both little-endian, shifted in from the top.
          if (hdr_index < 4'd4) begin
            tag_word = {b, tag_word[31:8]};
          end else begin
            body_left = {b, body_left[31:8]};
          end
          if (hdr_index < 4'd7) begin
            hdr_index = hdr_index + 4'd1;
          end else begin
            hdr_index = '0;
            if (tag_word == TAG_DATA) begin
              if (!fmt_ok) begin
                res = error_result(ERR_NO_FMT);
                produced = 1'b1;
              end else begin
                block_index = '0;
                if (body_left == 32'd0) begin
                  walk_phase = PH_DONE;
                end else begin
                  walk_phase = PH_DATA;
                end
              end
            end else if (tag_word == TAG_FMT && !fmt_ok) begin
              fmt_code = '0;
              rate_word = '0;
              align_bytes = '0;
              sample_bits = '0;
              if (body_left == 32'd0) begin
                res = judge_format();
                produced = 1'b1;
              end else begin
                walk_phase = PH_FMT;
              end
            end else if (body_left != 32'd0) begin
              // Unknown chunks and any later fmt chunk are passed over.
              walk_phase = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          field_off = 32'(hdr_index);
          if (field_off < 2) begin
            fmt_code = fmt_code | (16'(b) << (8 * field_off));
          end else if (field_off >= 4 && field_off < 8) begin
            rate_word = rate_word | (32'(b) << (8 * (field_off - 4)));
          end else if (field_off >= 12 && field_off < 14) begin
            align_bytes = align_bytes | (16'(b) << (8 * (field_off - 12)));
          end else if (field_off >= 14) begin
            sample_bits = sample_bits | (16'(b) << (8 * (field_off - 14)));
          end
          body_left = body_left - 32'd1;
          hdr_index = hdr_index + 4'd1;
          // The check runs after the bits field or at the end of a short chunk.
          if (field_off == 15 || body_left == 32'd0) begin
            if (body_left == 32'd0) begin
              walk_phase = PH_HEAD;
            end else begin
              walk_phase = PH_SKIP;
            end
            hdr_index = '0;
            res = judge_format();
            produced = 1'b1;
          end
        end
        PH_SKIP: begin
          body_left = body_left - 32'd1;
          if (body_left == 32'd0) begin
            walk_phase = PH_HEAD;
            hdr_index = '0;
          end
        end
        PH_DATA: begin
          // A block counts only if the chunk still holds all of its bytes.
          left_before = longint'(body_left);
          need = longint'(align_bytes) - longint'(block_index);
          complete = (left_before >= need);
          no_more = complete && ((left_before - need) < longint'(align_bytes));
          if (sample_bits == 16'd8) begin
            if (block_index == 16'd0) begin
              emit = 1'b1;
              sample = {b ^ 8'h80, 8'h00};
            end
          end else begin
            if (block_index == 16'd0) begin
              low_byte = b;
              // With a one-byte block the high byte never comes: take it as zero.
              if (align_bytes == 16'd1) begin
                emit = 1'b1;
                raw = {8'h00, b};
              end
            end else if (block_index == 16'd1) begin
              emit = 1'b1;
              raw = {b, low_byte};
            end
            if (raw == SAMPLE_MIN) begin
              raw = SAMPLE_CLAMP;
            end
            sample = raw;
          end
          if (emit && complete) begin
            res.kind = KIND_SAMPLE;
            res.sample_value = sample;
            res.final_sample = no_more;
            produced = 1'b1;
          end
          body_left = body_left - 32'd1;
          block_index = block_index + 16'd1;
          if (block_index >= align_bytes) begin
            block_index = '0;
          end
          if (body_left == 32'd0) begin
            walk_phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
    if (eof) begin
      // A file that never reached its data chunk ends in an error, which
      // takes the place of a format result from the same byte.
      if (!stuck_error && walk_phase < PH_DATA) begin
        if (fmt_ok) begin
          res = error_result(ERR_NO_DATA);
        end else begin
          res = error_result(ERR_NO_FMT);
        end
        produced = 1'b1;
      end
      clear_parser();
    end
    if (produced) begin
      awaited_results.push_back(res);
    end
  endtask

  // Offers one item and waits until it is taken. The sender runs in bursts;
  // valid only drops in the step of an earlier acceptance.
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(60, 200);
      end else begin
        burst_left = $urandom_range(1, 16);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    file_byte_i   <= value;
    end_of_file_i <= is_last;
    parse_wave_byte(value, is_last);
    bytes_sent++;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  function automatic void put_le(input logic [31:0] value, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      file_q.push_back(value[8*i +: 8]);
    end
  endfunction

  function automatic void put_random_bytes(input int unsigned count);
    repeat (count) file_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_chunk_head(input logic [31:0] tag, input logic [31:0] size);
    put_le(tag, 4);
    put_le(size, 4);
  endfunction

  // "RIFF", a random size and "WAVE": the parser passes over all twelve.
  function automatic void put_form_header();
    put_le(32'h4646_4952, 4);
    put_le($urandom, 4);
    put_le(32'h4556_4157, 4);
  endfunction

  // A fmt chunk of the given size; channel count and byte rate are random,
  // and a chunk shorter than 16 bytes simply stops partway through.
  function automatic void put_fmt_chunk(input logic [15:0] code, input logic [31:0] rate,
                                        input logic [15:0] align, input logic [15:0] bits,
                                        input int unsigned size);
    put_chunk_head(TAG_FMT, size);
    for (int unsigned i = 0; i < size; i++) begin
      if (i < 2) begin
        file_q.push_back(code[8*i +: 8]);
      end else if (i >= 4 && i < 8) begin
        file_q.push_back(rate[8*(i-4) +: 8]);
      end else if (i >= 12 && i < 14) begin
        file_q.push_back(align[8*(i-12) +: 8]);
      end else if (i >= 14 && i < 16) begin
        file_q.push_back(bits[8*(i-14) +: 8]);
      end else begin
        file_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Sends the assembled file, marking its last byte as the end of file.
  task automatic send_file();
    for (int unsigned i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == file_q.size() - 1);
    end
    file_q.delete();
  endtask

  // Sample decoding: clamping, the 8-bit offset, the one-byte 16-bit block,
  // incomplete blocks, bytes after the data chunk, a file ending mid-chunk.
  task automatic test_sample_decoding();
    put_form_header();
    put_chunk_head(32'h5453_494C, 3);
    put_random_bytes(3);
    put_fmt_chunk(PCM_TAG, 32'hFFFF_FFFF, 16'd4, 16'd16, 16);
    put_chunk_head(TAG_DATA, 14);
    put_le(32'hA5A5_8000, 4);
    put_le(32'h0000_7FFF, 4);
    put_le(32'h5A5A_FFFF, 4);
    put_le(32'h0000_0001, 2);
    put_random_bytes(3);
    send_file();

    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd0, 16'd1, 16'd8, 16);
    put_chunk_head(TAG_DATA, 3);
    put_le(32'h00FF_8000, 3);
    send_file();

    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd44100, 16'd1, 16'd16, 18);
    put_chunk_head(TAG_DATA, 32'h0000_1000);
    put_le(32'h0000_00FF, 2);
    send_file();
  endtask

  // Every error code, the error order rules, and the chunks that are skipped.
  task automatic test_format_errors();
    put_form_header();
    put_fmt_chunk(16'd3, 32'd8000, 16'd2, 16'd16, 16);
    put_chunk_head(TAG_DATA, 2);
    put_random_bytes(2);
    send_file();

    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd8000, 16'd3, 16'd24, 16);
    send_file();

    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd8000, 16'd0, 16'd8, 16);
    send_file();

    // Data ahead of any fmt chunk.
    put_form_header();
    put_chunk_head(TAG_DATA, 2);
    put_random_bytes(2);
    put_fmt_chunk(PCM_TAG, 32'd8000, 16'd2, 16'd16, 16);
    send_file();

    // A good format but no data chunk before the end of file.
    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd11025, 16'd2, 16'd16, 16);
    put_chunk_head(32'h6B6E_756A, 2);
    put_random_bytes(2);
    send_file();

    // The end of file lands on the byte that completes the format check.
    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd16000, 16'd2, 16'd8, 16);
    send_file();

    // End of file inside the form header.
    put_random_bytes(5);
    send_file();

    // An empty fmt chunk reads as format tag zero.
    put_form_header();
    put_chunk_head(TAG_FMT, 0);
    put_random_bytes(2);
    send_file();

    // A fmt chunk cut short before the bits field.
    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd22050, 16'd2, 16'd16, 6);
    send_file();

    // A long fmt chunk, a second fmt chunk that is ignored, an empty data chunk.
    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd48000, 16'd2, 16'd16, 20);
    put_fmt_chunk(16'd3, 32'd0, 16'd0, 16'd0, 16);
    put_chunk_head(TAG_DATA, 0);
    put_random_bytes(2);
    send_file();
  endtask

  // The receiver holds off for a long stretch while a file full of samples
  // keeps coming, so the block fills and drops in_ready_o.
  task automatic test_output_holdoff();
    put_form_header();
    put_fmt_chunk(PCM_TAG, 32'd8000, 16'd1, 16'd8, 16);
    put_chunk_head(TAG_DATA, 64);
    put_random_bytes(64);
    holdoff_requests++;
    send_file();
  endtask

  // Mostly well-formed files with random content, mixed with broken and noisy ones.
  task automatic test_random_files();
    int unsigned pick;
    int unsigned junk_len;
    int unsigned data_len;
    int unsigned cut;
    logic [15:0] code;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] declared;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick >= 8) begin
        put_random_bytes($urandom_range(1, 40));
      end else begin
        put_form_header();
        repeat ($urandom_range(0, 2)) begin
          junk_len = $urandom_range(0, 6);
          put_chunk_head($urandom, junk_len);
          put_random_bytes(junk_len);
        end
        if (pick == 7) begin
          put_chunk_head(TAG_DATA, 4);
          put_random_bytes(4);
        end
        code = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PCM_TAG;
        if ($urandom_range(0, 9) == 0) begin
          bits = 16'($urandom);
        end else if ($urandom_range(0, 1) == 0) begin
          bits = 16'd8;
        end else begin
          bits = 16'd16;
        end
        case ($urandom_range(0, 15))
          0: align = 16'd0;
          1: align = 16'($urandom);
          default: align = 16'($urandom_range(1, 6));
        endcase
        put_fmt_chunk(code, $urandom, align, bits,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : 16);
        if ($urandom_range(0, 3) == 0) begin
          put_fmt_chunk(16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                        $urandom_range(0, 20));
        end
        if ($urandom_range(0, 9) != 0) begin
          data_len = $urandom_range(0, 40);
          declared = ($urandom_range(0, 7) == 0) ? $urandom : data_len;
          put_chunk_head(TAG_DATA, declared);
          put_random_bytes(data_len);
          put_random_bytes($urandom_range(0, 5));
        end
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, file_q.size());
          while (file_q.size() > cut) file_q.pop_back();
        end
      end
      send_file();
    end
  endtask

  // Receiver: changes its stall mode now and then and serves hold-off requests.
  always @(posedge clk_i) begin
    rx_tick++;
    if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_MOSTLY:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:  out_ready_i <= ($urandom_range(0, 3) == 0);
        default:    out_ready_i <= ((rx_tick % 5) < 2);
      endcase
    end
  end

  // Each accepted result is held against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result item arrived with none predicted");
      end else begin
        want = awaited_results.pop_front();
        if (kind_o !== want.kind) begin
          report_mismatch($sformatf("kind %0d, predicted %0d", kind_o, want.kind));
        end
        if (sample_value_o !== want.sample_value) begin
          report_mismatch($sformatf("sample_value %0d, predicted %0d",
                                    sample_value_o, want.sample_value));
        end
        if (final_sample_o !== want.final_sample) begin
          report_mismatch($sformatf("final_sample %0b, predicted %0b",
                                    final_sample_o, want.final_sample));
        end
        if (rate_hz_o !== want.rate_hz) begin
          report_mismatch($sformatf("rate_hz %0h, predicted %0h", rate_hz_o, want.rate_hz));
        end
        if (block_bytes_o !== want.block_bytes) begin
          report_mismatch($sformatf("block_bytes %0d, predicted %0d",
                                    block_bytes_o, want.block_bytes));
        end
        if (error_code_o !== want.error_code) begin
          report_mismatch($sformatf("error_code %0d, predicted %0d",
                                    error_code_o, want.error_code));
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("wav_pcm_stream_parser_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    file_byte_i   <= 8'h00;
    end_of_file_i <= 1'b0;
    out_ready_i   <= 1'b0;
    bytes_sent       = 0;
    error_count      = 0;
    burst_left       = 0;
    idle_cycles      = 0;
    holdoff_requests = 0;
    holdoff_served   = 0;
    holdoff_left     = 0;
    mode_left        = 0;
    rx_tick          = 0;
    rx_mode          = RX_ALWAYS;
    clear_parser();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_decoding();
    test_format_errors();
    test_output_holdoff();
    test_random_files();

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("wav_pcm_stream_parser_top_tb: clean");
    end else begin
      $display("wav_pcm_stream_parser_top_tb: errors");
    end
    $finish;
  end

endmodule
